// ----- rtl/rpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared widths and the sequencer state type of the return path counter.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int unsigned LenW   = 6;
  localparam int unsigned RetW   = 5;
  localparam int unsigned CountW = 64;

  typedef enum logic [1:0] {
    StIdle,
    StSweep,
    StDrain,
    StFinish
  } state_e;

endpackage

// ----- rtl/rpc_ram.sv -----
// ----------------------------------------------------------------------------
// rpc_ram
// Simple dual-port count buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rpc_ram #(
  parameter int unsigned Depth = 561,
  parameter int unsigned AddrW = 10
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [rpc_pkg::CountW-1:0] wdata_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [rpc_pkg::CountW-1:0] rdata_o
);
  import rpc_pkg::*;

  logic [CountW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/return_path_counter_core.sv -----
// ----------------------------------------------------------------------------
// return_path_counter_core
// Counts height-bounded paths from height one to zero with a given number of
// returns, by a step-by-step table sweep over two ping-pong count buffers.
// ----------------------------------------------------------------------------
// Usage: an item (path_length_i, return_count_i) is taken on in_valid_i and
// in_ready_o; one item (path_count_o) is offered per input on out_valid_o and
// taken on out_ready_i. Both channels are valid/ready.
// The block works on one item at a time and raises in_ready_o only when idle.
// Each path step sweeps the whole table, one entry per cycle, reading the
// current buffer through its single read port while writing the other one.
// After each sweep a drain state lets the last write finish and swaps the
// buffers; after the last step the result goes to the output register, and
// only once it is in that register can the next item be taken. A zero length,
// or a length or return count beyond its maximum, gives its count of 0 with no
// sweep, and the next item can be taken once that count is in the register.
// The first step takes its operands from the seed rather than the buffer, and
// every later step reads only entries written by the step before, so no
// clearing pass is needed after reset or between items.
// The result sits in an output register. While the receiver stalls, a finished
// item waits until that register is free, and only then does the block return
// to idle and accept the next item.
// Reset returns the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
module return_path_counter_core #(
  parameter int unsigned MAX_LENGTH  = 32,
  parameter int unsigned MAX_RETURNS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [rpc_pkg::LenW-1:0]   path_length_i,
  input  logic [rpc_pkg::RetW-1:0]   return_count_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rpc_pkg::CountW-1:0] path_count_o
);
  import rpc_pkg::*;

  localparam int unsigned Depth = (MAX_LENGTH + 1) * (MAX_RETURNS + 1);
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned KW    = $clog2(MAX_LENGTH + 2);
  localparam int unsigned RW    = $clog2(MAX_RETURNS + 1);
  localparam logic [KW-1:0] KLast = KW'(MAX_LENGTH + 1);
  localparam logic [RW-1:0] RLast = RW'(MAX_RETURNS);
  localparam logic [KW-1:0] KOne  = KW'(1);

  state_e state_q, state_d;

  logic [LenW-1:0]   steps_q, steps_d;
  logic [RetW-1:0]   want_q, want_d;
  logic [LenW-1:0]   pos_q, pos_d;
  logic [KW-1:0]     k_q, k_d;
  logic [RW-1:0]     r_q, r_d;
  logic              sel_q, sel_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;
  logic [AW-1:0]     wr_addr_q, wr_addr_d;
  logic              s1_valid_q, s1_valid_d;
  logic [KW-1:0]     s1_k_q, s1_k_d;
  logic [RW-1:0]     s1_r_q, s1_r_d;
  logic [CountW-1:0] w_cur_q, w_cur_d;
  logic [CountW-1:0] pair_q, pair_d;
  logic [CountW-1:0] save_q, save_d;
  logic [CountW-1:0] res_q, res_d;
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] out_data_q, out_data_d;

  logic              accept;
  logic              bad_item;
  logic              sweep_end;
  logic              last_step;
  logic              out_free;
  logic              issue;
  logic [CountW-1:0] rdata0, rdata1, rdata;
  logic [CountW-1:0] v;
  logic [CountW-1:0] down;
  logic [CountW-1:0] wsum;
  logic              we;

  assign accept    = in_valid_i && in_ready_o;
  assign bad_item  = (32'(path_length_i) > MAX_LENGTH) || (32'(return_count_i) > MAX_RETURNS)
                     || (path_length_i == '0);
  assign sweep_end = (k_q == KLast) && (r_q == RLast);
  assign last_step = ((pos_q + LenW'(1)) == steps_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign issue     = (state_q == StSweep);

  rpc_ram #(.Depth(Depth), .AddrW(AW)) u_buf0 (
    .clk_i   (clk_i),
    .we_i    (we && sel_q),
    .waddr_i (wr_addr_q),
    .wdata_i (wsum),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata0)
  );

  rpc_ram #(.Depth(Depth), .AddrW(AW)) u_buf1 (
    .clk_i   (clk_i),
    .we_i    (we && !sel_q),
    .waddr_i (wr_addr_q),
    .wdata_i (wsum),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata1)
  );

  // Stage one: the entry at height k arrives, and height k-1 of the next
  // table is formed from the two entries below it plus the descent term.
  always_comb begin
    rdata = sel_q ? rdata1 : rdata0;
    if (pos_q == '0) begin
      v = (s1_k_q == KOne && s1_r_q == '0) ? CountW'(1) : '0;
    end else if (s1_k_q == KLast) begin
      v = '0;
    end else begin
      v = rdata;
    end
    // A descent to height zero comes from height one with one return fewer.
    if (s1_k_q == KOne) begin
      down = (s1_r_q == '0) ? '0 : save_q;
    end else begin
      down = v;
    end
    wsum = pair_q + down;
    we   = s1_valid_q && (s1_k_q != '0);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = bad_item ? StFinish : StSweep;
        end
      end
      StSweep: begin
        if (sweep_end) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = last_step ? StFinish : StSweep;
      end
      StFinish: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    steps_d     = steps_q;
    want_d      = want_q;
    pos_d       = pos_q;
    k_d         = k_q;
    r_d         = r_q;
    sel_d       = sel_q;
    rd_addr_d   = rd_addr_q;
    wr_addr_d   = wr_addr_q;
    s1_valid_d  = issue;
    s1_k_d      = k_q;
    s1_r_d      = r_q;
    w_cur_d     = w_cur_q;
    pair_d      = pair_q;
    save_d      = save_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    in_ready_o  = (state_q == StIdle);

    if (we) begin
      wr_addr_d = wr_addr_q + AW'(1);
    end

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          steps_d   = path_length_i;
          want_d    = return_count_i;
          pos_d     = '0;
          k_d       = '0;
          r_d       = '0;
          sel_d     = 1'b0;
          rd_addr_d = '0;
          wr_addr_d = '0;
          res_d     = '0;
        end
      end
      StSweep: begin
        if (k_q == KLast) begin
          k_d = '0;
          r_d = (r_q == RLast) ? '0 : r_q + RW'(1);
        end else begin
          k_d       = k_q + KW'(1);
          rd_addr_d = rd_addr_q + AW'(1);
        end
      end
      StDrain: begin
        pos_d     = pos_q + LenW'(1);
        sel_d     = !sel_q;
        rd_addr_d = '0;
        wr_addr_d = '0;
      end
      StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
        end
      end
      default: ;
    endcase

    if (s1_valid_q) begin
      w_cur_d = v;
      pair_d  = (s1_k_q == '0) ? v : v + w_cur_q;
      if (s1_k_q == KOne) begin
        save_d = v;
        if (last_step && (32'(s1_r_q) == 32'(want_q))) begin
          res_d = wsum;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      k_q         <= '0;
      r_q         <= '0;
      sel_q       <= 1'b0;
      rd_addr_q   <= '0;
      wr_addr_q   <= '0;
    end else begin
      state_q     <= state_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      k_q         <= k_d;
      r_q         <= r_d;
      sel_q       <= sel_d;
      rd_addr_q   <= rd_addr_d;
      wr_addr_q   <= wr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q    <= steps_d;
    want_q     <= want_d;
    s1_k_q     <= s1_k_d;
    s1_r_q     <= s1_r_d;
    w_cur_q    <= w_cur_d;
    pair_q     <= pair_d;
    save_q     <= save_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o  = out_valid_q;
  assign path_count_o = out_data_q;

endmodule

// ----- rtl/rpc_checker.sv -----
// ----------------------------------------------------------------------------
// rpc_checker
// Port-level checks of the return path counter, bound to the top level.
// ----------------------------------------------------------------------------
module rpc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [rpc_pkg::LenW-1:0]   path_length_i,
  input logic [rpc_pkg::RetW-1:0]   return_count_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [rpc_pkg::CountW-1:0] path_count_o
);
  import rpc_pkg::*;

  // A stalled result is held unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(path_count_o))
    else $error("result changed or dropped while stalled");

  // Taking an item starts work, so the block stops accepting.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still ready after an item was accepted");

  // A result only appears at the end of a period of work.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a preceding busy period");

  // An idle block with no incoming item produces nothing.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !in_valid_i |=> !$rose(out_valid_o))
    else $error("result produced without an item");

endmodule

bind return_path_counter_core rpc_checker u_rpc_checker (.*);
